### rtl/ntlv_pkg.sv
// ============================================================================
// ntlv_pkg - shared types and constants of the nested tlv stream parser
// token codes, error codes, register indexes, reset values and default sizes
// ============================================================================
package ntlv_pkg;

    // default sizes
    localparam int MAX_NEST_DEF      = 8;
    localparam int MAX_MSG_BYTES_DEF = 256;

    // results one input word may cause
    localparam int MAX_RESULTS = 10;

    // integer value bytes that fit the value register
    localparam int INT_BYTES = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_INT_CODE    = 2'd0;
    localparam logic [1:0] CFG_UINT_CODE   = 2'd1;
    localparam logic [1:0] CFG_STRING_CODE = 2'd2;
    localparam logic [1:0] CFG_STRUCT_CODE = 2'd3;

    // configuration reset values
    localparam logic [7:0] INT_CODE_RST    = 8'd1;
    localparam logic [7:0] UINT_CODE_RST   = 8'd2;
    localparam logic [7:0] STRING_CODE_RST = 8'd3;
    localparam logic [7:0] STRUCT_CODE_RST = 8'd4;

    typedef enum logic [2:0] {
        TK_INT          = 3'd0,
        TK_UINT         = 3'd1,
        TK_STR_START    = 3'd2,
        TK_STR_BYTE     = 3'd3,
        TK_STRUCT_BEGIN = 3'd4,
        TK_STRUCT_END   = 3'd5,
        TK_UNKNOWN      = 3'd6,
        TK_MSG_END      = 3'd7
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNCATED = 2'd1,
        ERR_OVERFLOW  = 2'd2
    } err_code_t;

endpackage

### rtl/ntlv_stack_mem.sv
// ============================================================================
// ntlv_stack_mem - struct end position stack storage
// one write port, one registered read port, write data forwarded on a
// same-address read
// ============================================================================
module ntlv_stack_mem #(
    parameter int DEPTH  = ntlv_pkg::MAX_NEST_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read sees a write to the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/nested_tlv_stream_parser.sv
// ============================================================================
// nested_tlv_stream_parser - streaming type-length-value parser
// parses one message byte per input word into int, uint, string, struct,
// unknown and message end tokens; open structs are tracked on a stack in memory
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//  in      | in_valid, in_ready   | msg_byte, end_of_msg
//  out     | out_valid, out_ready | token_kind .. error_code, last_result
//
//  steps: a byte goes through accept, pre-pop, parse, post-pop, flush;
//  struct ends pop in pre-pop and post-pop, and a message end byte adds
//  a message end step before flush; the struct stack read port is registered
//  and follows the stack pointer, so pops go at one per cycle unless stalled
//  reset: no clearing pass; stack entries are only read after being pushed
//  stalls: a result waits in a pending register and then the output
//  register; the sequencer holds while both are full
//
module nested_tlv_stream_parser #(
    parameter int MAX_NEST      = ntlv_pkg::MAX_NEST_DEF,
    parameter int MAX_MSG_BYTES = ntlv_pkg::MAX_MSG_BYTES_DEF,
    parameter int SP_W          = $clog2(MAX_NEST + 1)
) (
    input  logic            clk,
    input  logic            rst_n,

    // configuration
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data,

    // message bytes
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      msg_byte,
    input  logic            end_of_msg,

    // tokens
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      token_kind,
    output logic [7:0]      type_byte,
    output logic [7:0]      elem_length,
    output logic [31:0]     int_value,
    output logic            too_long,
    output logic [7:0]      string_byte,
    output logic [SP_W-1:0] nest_depth,
    output logic            all_closed,
    output logic [1:0]      error_code,
    output logic            last_result
);

    localparam int ADDR_W  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int POS_W   = $clog2(MAX_MSG_BYTES + 1);
    // end position: position plus a length of up to 255
    localparam int ENTRY_W = $clog2(MAX_MSG_BYTES + 256);
    localparam int CNT_W   = $clog2(ntlv_pkg::MAX_RESULTS + 1);

    localparam logic [CNT_W-1:0] LIM_PRE  = CNT_W'(ntlv_pkg::MAX_RESULTS - 2);
    localparam logic [CNT_W-1:0] LIM_LAST = CNT_W'(ntlv_pkg::MAX_RESULTS - 1);
    localparam logic [CNT_W-1:0] LIM_FULL = CNT_W'(ntlv_pkg::MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_TAKE,
        ST_POST,
        ST_ENDMSG,
        ST_FLUSH
    } state_t;

    // which field of an element the next byte belongs to
    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_VAL
    } phase_t;

    typedef enum logic [1:0] {
        VK_INT,
        VK_UINT,
        VK_STR
    } vkind_t;

    typedef struct packed {
        ntlv_pkg::token_kind_t kind;
        logic [7:0]            type_b;
        logic [7:0]            len;
        logic [31:0]           val;
        logic                  too_long;
        logic [7:0]            sbyte;
        logic [SP_W-1:0]       depth;
        logic                  all_closed;
        ntlv_pkg::err_code_t   err;
    } result_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0] int_code_reg;
    logic [7:0] uint_code_reg;
    logic [7:0] str_code_reg;
    logic [7:0] struct_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_code_reg    <= ntlv_pkg::INT_CODE_RST;
            uint_code_reg   <= ntlv_pkg::UINT_CODE_RST;
            str_code_reg    <= ntlv_pkg::STRING_CODE_RST;
            struct_code_reg <= ntlv_pkg::STRUCT_CODE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ntlv_pkg::CFG_INT_CODE:    int_code_reg    <= cfg_data;
                ntlv_pkg::CFG_UINT_CODE:   uint_code_reg   <= cfg_data;
                ntlv_pkg::CFG_STRING_CODE: str_code_reg    <= cfg_data;
                ntlv_pkg::CFG_STRUCT_CODE: struct_code_reg <= cfg_data;
                default:                   int_code_reg    <= int_code_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and parse state
    // ------------------------------------------------------------------
    state_t            state_reg,   state_next;
    logic [7:0]        byte_reg,    byte_next;     // latched input word
    logic              last_reg,    last_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;      // results of this word so far
    phase_t            phase_reg,   phase_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [7:0]        type_reg,    type_next;
    logic [7:0]        rem_reg,     rem_next;
    logic [7:0]        len_reg,     len_next;
    vkind_t            kind_reg,    kind_next;
    logic [31:0]       acc_reg,     acc_next;
    logic [SP_W-1:0]   sp_reg,      sp_next;

    // pending result, held back until it is known whether it is the last one
    result_t           pend_reg,    pend_next;
    logic              pend_v_reg,  pend_v_next;
    result_t           out_reg,     out_next;
    logic              out_v_reg,   out_v_next;
    logic              out_last_reg, out_last_next;

    // stack memory port
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0]  top_entry;
    logic [SP_W-1:0]     sp_m1;

    logic                out_free;
    logic                can_produce;
    logic                produce;
    result_t             new_res;
    logic                pop_ready;
    logic [CNT_W-1:0]    post_lim;
    logic [7:0]          rem_dec;
    logic [31:0]         acc_shift;

    assign out_free    = !out_v_reg || out_ready;
    assign can_produce = !pend_v_reg || out_free;

    // top of stack is always the entry below the pointer
    assign pop_ready = (phase_reg == PH_TYPE) && (sp_reg != '0)
                     && (ENTRY_W'(pos_reg) >= top_entry);
    assign post_lim  = last_reg ? LIM_LAST : LIM_FULL;
    assign rem_dec   = rem_reg - 8'd1;
    assign acc_shift = {acc_reg[23:0], byte_reg};

    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        type_next     = type_reg;
        rem_next      = rem_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        acc_next      = acc_reg;
        sp_next       = sp_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && !out_ready;
        out_last_next = out_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = sp_reg[ADDR_W-1:0];
        mem_wdata     = ENTRY_W'(pos_reg) + ENTRY_W'(1) + ENTRY_W'(byte_reg);
        produce       = 1'b0;
        new_res       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next  = msg_byte;
                    last_next  = end_of_msg;
                    cnt_next   = '0;
                    state_next = ST_PRE;
                end
            end

            ST_PRE, ST_POST:
            begin
                if (pop_ready && (cnt_reg < ((state_reg == ST_PRE) ? LIM_PRE : post_lim)))
                begin
                    if (can_produce)
                    begin
                        produce        = 1'b1;
                        new_res.kind   = ntlv_pkg::TK_STRUCT_END;
                        new_res.type_b = struct_code_reg;
                        new_res.depth  = sp_reg - SP_W'(1);
                        sp_next        = sp_reg - SP_W'(1);
                    end
                end
                else if (state_reg == ST_PRE)
                begin
                    state_next = ST_TAKE;
                end
                else
                begin
                    state_next = last_reg ? ST_ENDMSG : ST_FLUSH;
                end
            end

            ST_TAKE:
            begin
                if (can_produce)
                begin
                    state_next = ST_POST;
                    // bytes past capacity are dropped
                    if (pos_reg < POS_W'(MAX_MSG_BYTES))
                    begin
                        pos_next = pos_reg + POS_W'(1);
                        case (phase_reg)
                            PH_TYPE:
                            begin
                                type_next  = byte_reg;
                                phase_next = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                len_next       = byte_reg;
                                rem_next       = byte_reg;
                                acc_next       = '0;
                                phase_next     = PH_TYPE;
                                new_res.type_b = type_reg;
                                new_res.len    = byte_reg;
                                new_res.depth  = sp_reg;
                                if ((type_reg == int_code_reg) || (type_reg == uint_code_reg))
                                begin
                                    kind_next    = (type_reg == int_code_reg) ? VK_INT : VK_UINT;
                                    new_res.kind = (type_reg == int_code_reg)
                                                 ? ntlv_pkg::TK_INT : ntlv_pkg::TK_UINT;
                                    // zero length integer completes here with value 0
                                    if (byte_reg == 8'd0)
                                    begin
                                        produce = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_VAL;
                                    end
                                end
                                else if (type_reg == str_code_reg)
                                begin
                                    kind_next    = VK_STR;
                                    produce      = 1'b1;
                                    new_res.kind = ntlv_pkg::TK_STR_START;
                                    if (byte_reg != 8'd0)
                                    begin
                                        phase_next = PH_VAL;
                                    end
                                end
                                else if (type_reg == struct_code_reg)
                                begin
                                    produce      = 1'b1;
                                    new_res.kind = ntlv_pkg::TK_STRUCT_BEGIN;
                                    if (sp_reg < SP_W'(MAX_NEST))
                                    begin
                                        mem_we        = 1'b1;
                                        sp_next       = sp_reg + SP_W'(1);
                                        new_res.depth = sp_reg + SP_W'(1);
                                    end
                                    else
                                    begin
                                        // full stack: contents count as siblings
                                        new_res.err = ntlv_pkg::ERR_OVERFLOW;
                                    end
                                end
                                else
                                begin
                                    produce      = 1'b1;
                                    new_res.kind = ntlv_pkg::TK_UNKNOWN;
                                end
                            end
                            PH_VAL:
                            begin
                                rem_next       = rem_dec;
                                new_res.type_b = type_reg;
                                new_res.len    = len_reg;
                                new_res.depth  = sp_reg;
                                if (kind_reg == VK_STR)
                                begin
                                    produce       = 1'b1;
                                    new_res.kind  = ntlv_pkg::TK_STR_BYTE;
                                    new_res.sbyte = byte_reg;
                                end
                                else
                                begin
                                    acc_next = acc_shift;
                                    if (rem_dec == 8'd0)
                                    begin
                                        produce          = 1'b1;
                                        new_res.kind     = (kind_reg == VK_INT)
                                                         ? ntlv_pkg::TK_INT : ntlv_pkg::TK_UINT;
                                        new_res.val      = acc_shift;
                                        new_res.too_long = (len_reg > 8'(ntlv_pkg::INT_BYTES));
                                    end
                                end
                                if (rem_dec == 8'd0)
                                begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_TYPE;
                            end
                        endcase
                    end
                end
            end

            ST_ENDMSG:
            begin
                if (can_produce)
                begin
                    produce            = 1'b1;
                    new_res.kind       = ntlv_pkg::TK_MSG_END;
                    new_res.depth      = sp_reg;
                    new_res.all_closed = (sp_reg == '0);
                    new_res.err        = (phase_reg != PH_TYPE)
                                       ? ntlv_pkg::ERR_TRUNCATED : ntlv_pkg::ERR_NONE;
                    // back to the start of a message, registers kept
                    phase_next = PH_TYPE;
                    pos_next   = '0;
                    type_next  = '0;
                    rem_next   = '0;
                    len_next   = '0;
                    kind_next  = VK_INT;
                    acc_next   = '0;
                    sp_next    = '0;
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                // the held result is the last one of this word
                if (!pend_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next      = pend_reg;
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result pushes the held one on to the output register
        if (produce)
        begin
            if (pend_v_reg)
            begin
                out_next      = pend_reg;
                out_last_next = 1'b0;
                out_v_next    = 1'b1;
            end
            pend_next   = new_res;
            pend_v_next = 1'b1;
            cnt_next    = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_reg     <= '0;
            last_reg     <= 1'b0;
            cnt_reg      <= '0;
            phase_reg    <= PH_TYPE;
            pos_reg      <= '0;
            type_reg     <= '0;
            rem_reg      <= '0;
            len_reg      <= '0;
            kind_reg     <= VK_INT;
            acc_reg      <= '0;
            sp_reg       <= '0;
            pend_reg     <= '0;
            pend_v_reg   <= 1'b0;
            out_reg      <= '0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_reg     <= byte_next;
            last_reg     <= last_next;
            cnt_reg      <= cnt_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            type_reg     <= type_next;
            rem_reg      <= rem_next;
            len_reg      <= len_next;
            kind_reg     <= kind_next;
            acc_reg      <= acc_next;
            sp_reg       <= sp_next;
            pend_reg     <= pend_next;
            pend_v_reg   <= pend_v_next;
            out_reg      <= out_next;
            out_v_reg    <= out_v_next;
            out_last_reg <= out_last_next;
        end
    end

    // ------------------------------------------------------------------
    // struct end stack, read address tracks the next stack pointer
    // ------------------------------------------------------------------
    assign sp_m1     = sp_next - SP_W'(1);
    assign mem_raddr = sp_m1[ADDR_W-1:0];

    ntlv_stack_mem #(
        .DEPTH  (MAX_NEST),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_stack (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr  (mem_raddr),
        .rdata  (top_entry)
    );

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_v_reg;
    assign token_kind  = out_reg.kind;
    assign type_byte   = out_reg.type_b;
    assign elem_length = out_reg.len;
    assign int_value   = out_reg.val;
    assign too_long    = out_reg.too_long;
    assign string_byte = out_reg.sbyte;
    assign nest_depth  = out_reg.depth;
    assign all_closed  = out_reg.all_closed;
    assign error_code  = out_reg.err;
    assign last_result = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(MAX_NEST))
        else $error("stack pointer beyond nesting limit");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_MSG_BYTES))
        else $error("byte position beyond message capacity");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LIM_FULL)
        else $error("too many results for one word");

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("held result left behind at word end");

    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENDMSG && can_produce)
            |=> (sp_reg == '0 && pos_reg == '0 && phase_reg == PH_TYPE))
        else $error("parse state not cleared at message end");

endmodule

### tb/tb_nested_tlv_stream_parser.sv
// ============================================================================
// tb_nested_tlv_stream_parser - self-checking testbench of the tlv parser
// message bytes go in through the input handshake with random gaps, tokens
// come out through the output handshake with random stalls; a cycle-free
// model of the parser predicts the tokens of each accepted word and every
// token is compared field by field in order
// ============================================================================
module tb_nested_tlv_stream_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NEST_LIMIT  = ntlv_pkg::MAX_NEST_DEF;
    localparam int MSG_LIMIT   = ntlv_pkg::MAX_MSG_BYTES_DEF;
    // cycles a word may need inside the block with no token to show for it
    localparam int DRAIN       = 16;
    // cycles with no handshake at all before the run is given up
    localparam int STALL_LIMIT = 2000;

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  msg_byte;
    logic        end_of_msg;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  token_kind;
    logic [7:0]  type_byte;
    logic [7:0]  elem_length;
    logic [31:0] int_value;
    logic        too_long;
    logic [7:0]  string_byte;
    logic [3:0]  nest_depth;
    logic        all_closed;
    logic [1:0]  error_code;
    logic        last_result;

    nested_tlv_stream_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .msg_byte    (msg_byte),
        .end_of_msg  (end_of_msg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .token_kind  (token_kind),
        .type_byte   (type_byte),
        .elem_length (elem_length),
        .int_value   (int_value),
        .too_long    (too_long),
        .string_byte (string_byte),
        .nest_depth  (nest_depth),
        .all_closed  (all_closed),
        .error_code  (error_code),
        .last_result (last_result)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // token model
    // ------------------------------------------------------------------------
    typedef enum logic [1:0] {AT_TYPE, AT_LENGTH, AT_VALUE} field_phase_t;
    typedef enum logic [1:0] {VAL_INT, VAL_UINT, VAL_STRING} value_kind_t;

    typedef struct {
        ntlv_pkg::token_kind_t kind;
        logic [7:0]            type_code;
        logic [7:0]            length;
        logic [31:0]           value;
        logic                  too_long;
        logic [7:0]            str_byte;
        logic [3:0]            depth;
        logic                  closed;
        ntlv_pkg::err_code_t   err;
        logic                  last;
    } token_t;

    // type codes as last written
    logic [7:0]   code_int;
    logic [7:0]   code_uint;
    logic [7:0]   code_string;
    logic [7:0]   code_struct;

    // parse state
    field_phase_t phase;
    logic [8:0]   msg_pos;
    logic [7:0]   elem_type;
    logic [7:0]   elem_len;
    logic [7:0]   value_left;
    logic [31:0]  value_acc;
    value_kind_t  elem_kind;
    logic [9:0]   struct_end [NEST_LIMIT];
    logic [3:0]   open_structs;

    token_t       word_tokens[$];      // tokens of the word being modeled
    token_t       expected_tokens[$];  // tokens still owed by the block

    // run bookkeeping
    int fail_count;
    int tokens_checked;
    int words_taken;
    int msgs_sent;
    int cfg_writes;
    int in_stall_cycles;
    int send_burst;
    int recv_burst;
    int sink_hold;

    logic [7:0] msg_buf[$];

    function automatic void add_token(ntlv_pkg::token_kind_t kind, logic [7:0] tcode,
                                      logic [7:0] len, logic [31:0] val, logic tl,
                                      logic [7:0] sb, logic closed,
                                      ntlv_pkg::err_code_t err);
        token_t t;
        t.kind      = kind;
        t.type_code = tcode;
        t.length    = len;
        t.value     = val;
        t.too_long  = tl;
        t.str_byte  = sb;
        t.depth     = open_structs;
        t.closed    = closed;
        t.err       = err;
        t.last      = 1'b0;
        word_tokens.push_back(t);
    endfunction

    function automatic void clear_parse();
        phase        = AT_TYPE;
        msg_pos      = '0;
        elem_type    = '0;
        elem_len     = '0;
        value_left   = '0;
        value_acc    = '0;
        elem_kind    = VAL_INT;
        open_structs = '0;
        foreach (struct_end[i])
            struct_end[i] = '0;
    endfunction

    // struct ends only come out between elements, and only as many as fit
    function automatic void pop_ended_structs(int limit);
        while (phase == AT_TYPE && word_tokens.size() < limit && open_structs > 0 &&
               {1'b0, msg_pos} >= struct_end[open_structs - 1])
        begin
            open_structs = open_structs - 1'b1;
            add_token(ntlv_pkg::TK_STRUCT_END, code_struct, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0,
                      ntlv_pkg::ERR_NONE);
        end
    endfunction

    function automatic void add_int_token();
        add_token((elem_kind == VAL_INT) ? ntlv_pkg::TK_INT : ntlv_pkg::TK_UINT, elem_type,
                  elem_len, value_acc, elem_len > ntlv_pkg::INT_BYTES, 8'd0, 1'b0,
                  ntlv_pkg::ERR_NONE);
    endfunction

    function automatic void consume_byte(logic [7:0] b);
        ntlv_pkg::err_code_t err;
        msg_pos = msg_pos + 1'b1;
        case (phase)
            AT_TYPE:
            begin
                elem_type = b;
                phase     = AT_LENGTH;
            end
            AT_LENGTH:
            begin
                elem_len   = b;
                value_left = b;
                value_acc  = '0;
                phase      = AT_TYPE;
                // int beats uint beats string beats struct when codes collide
                if (elem_type == code_int || elem_type == code_uint)
                begin
                    elem_kind = (elem_type == code_int) ? VAL_INT : VAL_UINT;
                    if (b == 8'd0)
                        add_int_token();
                    else
                        phase = AT_VALUE;
                end
                else if (elem_type == code_string)
                begin
                    elem_kind = VAL_STRING;
                    add_token(ntlv_pkg::TK_STR_START, elem_type, b, 32'd0, 1'b0, 8'd0, 1'b0,
                              ntlv_pkg::ERR_NONE);
                    if (b != 8'd0)
                        phase = AT_VALUE;
                end
                else if (elem_type == code_struct)
                begin
                    err = ntlv_pkg::ERR_NONE;
                    if (open_structs < NEST_LIMIT)
                    begin
                        struct_end[open_structs] = {1'b0, msg_pos} + b;
                        open_structs = open_structs + 1'b1;
                    end
                    else
                        err = ntlv_pkg::ERR_OVERFLOW;
                    add_token(ntlv_pkg::TK_STRUCT_BEGIN, elem_type, b, 32'd0, 1'b0, 8'd0, 1'b0,
                              err);
                end
                else
                    add_token(ntlv_pkg::TK_UNKNOWN, elem_type, b, 32'd0, 1'b0, 8'd0, 1'b0,
                              ntlv_pkg::ERR_NONE);
            end
            default:
            begin
                value_left = value_left - 1'b1;
                if (elem_kind == VAL_STRING)
                    add_token(ntlv_pkg::TK_STR_BYTE, elem_type, elem_len, 32'd0, 1'b0, b, 1'b0,
                              ntlv_pkg::ERR_NONE);
                else
                begin
                    value_acc = {value_acc[23:0], b};
                    if (value_left == 8'd0)
                        add_int_token();
                end
                if (value_left == 8'd0)
                    phase = AT_TYPE;
            end
        endcase
    endfunction

    // tokens one accepted message word owes, appended to the expected list
    function automatic void predict_word_tokens(logic [7:0] b, logic eom);
        word_tokens.delete();
        pop_ended_structs(ntlv_pkg::MAX_RESULTS - 2);
        // bytes past the message capacity are dropped silently
        if (msg_pos < MSG_LIMIT)
            consume_byte(b);
        pop_ended_structs(eom ? ntlv_pkg::MAX_RESULTS - 1 : ntlv_pkg::MAX_RESULTS);
        if (eom)
        begin
            add_token(ntlv_pkg::TK_MSG_END, 8'd0, 8'd0, 32'd0, 1'b0, 8'd0, open_structs == 0,
                      (phase != AT_TYPE) ? ntlv_pkg::ERR_TRUNCATED : ntlv_pkg::ERR_NONE);
            clear_parse();
        end
        if (word_tokens.size() > 0)
            word_tokens[word_tokens.size() - 1].last = 1'b1;
        foreach (word_tokens[i])
            expected_tokens.push_back(word_tokens[i]);
    endfunction

    function automatic void apply_code_write(logic [1:0] idx, logic [7:0] val);
        case (idx)
            ntlv_pkg::CFG_INT_CODE:    code_int    = val;
            ntlv_pkg::CFG_UINT_CODE:   code_uint   = val;
            ntlv_pkg::CFG_STRING_CODE: code_string = val;
            ntlv_pkg::CFG_STRUCT_CODE: code_struct = val;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_token();
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token_kind mismatch: expected no token, got 0x%0h", token_kind);
            fail_count++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            tokens_checked++;
            compare_field("token_kind",  want.kind,      token_kind);
            compare_field("type_byte",   want.type_code, type_byte);
            compare_field("elem_length", want.length,    elem_length);
            compare_field("int_value",   want.value,     int_value);
            compare_field("too_long",    want.too_long,  too_long);
            compare_field("string_byte", want.str_byte,  string_byte);
            compare_field("nest_depth",  want.depth,     nest_depth);
            compare_field("all_closed",  want.closed,    all_closed);
            compare_field("error_code",  want.err,       error_code);
            compare_field("last_result", want.last,      last_result);
        end
    endfunction

    // every handshake is seen here at the rising edge, before the block
    // updates its outputs; register writes and words go to the model first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_code_write(cfg_index, cfg_data);
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (in_valid && in_ready)
            begin
                predict_word_tokens(msg_byte, end_of_msg);
                words_taken++;
            end
            if (out_valid && out_ready)
                check_token();
        end
    end

    // ------------------------------------------------------------------------
    // gaps and stalls: a random gap before each word, with gap-free bursts mixed in
    // ------------------------------------------------------------------------
    function automatic int pick_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // token sink: stalls at random, or for a long stretch when asked to
    initial
    begin : token_sink
        int gap;
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold      = sink_hold;
            sink_hold = 0;
            repeat (hold)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            gap = pick_gap(recv_burst);
            repeat (gap)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // no handshake of any kind for too long means the block hung
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no handshake for %0d cycles, %0d tokens still owed",
                 STALL_LIMIT, expected_tokens.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    // one message word; valid stays up across back-to-back words
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = pick_gap(send_burst);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        msg_byte   <= b;
        end_of_msg <= eom;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // sends the built message, end mark on its last byte
    task automatic send_message();
        foreach (msg_buf[i])
            send_byte(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
        msgs_sent++;
    endtask

    // all owed tokens in, then time for any word that owes none
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
    endtask

    task automatic write_code(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_type_codes(input logic [7:0] ci, input logic [7:0] cu,
                                  input logic [7:0] cs, input logic [7:0] cst);
        wait_quiet();
        write_code(ntlv_pkg::CFG_INT_CODE,    ci);
        write_code(ntlv_pkg::CFG_UINT_CODE,   cu);
        write_code(ntlv_pkg::CFG_STRING_CODE, cs);
        write_code(ntlv_pkg::CFG_STRUCT_CODE, cst);
    endtask

    task automatic push_bytes(input int count);
        repeat (count)
            msg_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // one element with a live or an unknown type code and random content, now and
    // then a stray byte instead
    task automatic append_random_element();
        int pick;
        int len;
        logic [7:0] t;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
        begin
            len = $urandom_range(0, 6);
            msg_buf.push_back(pick <= 1 ? code_int : code_uint);
            msg_buf.push_back(8'(len));
            push_bytes(len);
        end
        else if (pick <= 5)
        begin
            len = $urandom_range(0, 5);
            msg_buf.push_back(code_string);
            msg_buf.push_back(8'(len));
            push_bytes(len);
        end
        else if (pick <= 7)
        begin
            msg_buf.push_back(code_struct);
            msg_buf.push_back(8'($urandom_range(0, 14)));
        end
        else if (pick == 8)
        begin
            // unknown type: the length byte may be anything
            do
                t = 8'($urandom_range(0, 255));
            while (t == code_int || t == code_uint || t == code_string || t == code_struct);
            msg_buf.push_back(t);
            msg_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
            push_bytes(1);
    endtask

    // mostly well-formed; sometimes a short struct chain up front, sometimes
    // cut short at a random byte
    task automatic send_random_message();
        int elems;
        int cut;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
            begin
                msg_buf.push_back(code_struct);
                msg_buf.push_back(8'($urandom_range(0, 40)));
            end
        elems = $urandom_range(1, 3);
        repeat (elems)
            append_random_element();
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut)
                void'(msg_buf.pop_back());
        end
        send_message();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // every token kind but the struct ones at reset codes, extreme bytes, a message cut short
    task automatic test_basic_tokens();
        msg_buf = '{8'd1, 8'd4, 8'hFF, 8'h00, 8'hA5, 8'h5A,   // int, all bits
                    8'd2, 8'd5, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04, // uint over 4 bytes
                    8'd1, 8'd0,                                // int with no value
                    8'd3, 8'd0,                                // empty string
                    8'd3, 8'd1, 8'hFF,                         // one-byte string
                    8'hFF, 8'hFF,                              // unknown type
                    8'd1, 8'd2, 8'h7F};                        // ends mid value
        send_message();
        wait_quiet();
    endtask

    // nine nested structs: the ninth overflows, then all eight close on the
    // end byte, which makes the most tokens one word can cause
    task automatic test_deep_nesting();
        for (int k = 1; k <= NEST_LIMIT; k++)
        begin
            msg_buf.push_back(code_struct);
            msg_buf.push_back(8'(2 * (NEST_LIMIT + 1) - 2 * k));
        end
        msg_buf.push_back(code_struct);
        msg_buf.push_back(8'd0);
        send_message();
        wait_quiet();
    endtask

    task automatic test_random_messages(input int count);
        repeat (count)
            send_random_message();
        wait_quiet();
    endtask

    // extreme and colliding type codes, then back to the reset codes
    task automatic test_type_code_settings();
        set_type_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
        test_random_messages(1);
        set_type_codes(8'hFF, 8'h00, 8'h7F, 8'h80);
        test_random_messages(1);
        set_type_codes(8'h55, 8'h55, 8'h55, 8'h55);   // int wins
        test_random_messages(1);
        set_type_codes(8'hAA, 8'h33, 8'h33, 8'h33);   // uint wins
        test_random_messages(1);
        set_type_codes(8'h10, 8'h20, 8'hC0, 8'hC0);   // string wins over struct
        test_random_messages(1);
        set_type_codes(ntlv_pkg::INT_CODE_RST, ntlv_pkg::UINT_CODE_RST,
                       ntlv_pkg::STRING_CODE_RST, ntlv_pkg::STRUCT_CODE_RST);
    endtask

    // sink holds off long while a string streams in, so the block backs up
    task automatic test_output_hold();
        sink_hold  = 250;
        send_burst = 60;
        msg_buf.push_back(code_string);
        msg_buf.push_back(8'd18);
        push_bytes(18);
        send_message();
        wait_quiet();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        msg_byte   = '0;
        end_of_msg = 1'b0;
        code_int    = ntlv_pkg::INT_CODE_RST;
        code_uint   = ntlv_pkg::UINT_CODE_RST;
        code_string = ntlv_pkg::STRING_CODE_RST;
        code_struct = ntlv_pkg::STRUCT_CODE_RST;
        clear_parse();

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_tokens();
        test_deep_nesting();
        test_random_messages(2);
        test_type_code_settings();
        test_output_hold();

        wait_quiet();
        $display("covered %0d messages, %0d message words, %0d tokens compared",
                 msgs_sent, words_taken, tokens_checked);
        $display("%0d type code writes, %0d cycles an offered word waited on the block",
                 cfg_writes, in_stall_cycles);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
rtl/ntlv_pkg.sv
rtl/ntlv_stack_mem.sv
rtl/nested_tlv_stream_parser.sv
tb/tb_nested_tlv_stream_parser.sv
